>>> hdl/uta_pkg.sv
// Shared types and constants for the unreachable-target avoidance block.
// Command and status structs between controller and datapath, op and register codes.
// No dependencies.
package uta_pkg;

  localparam logic [6:0] ANGLE_MAX = 7'd89;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CHECK = 2'd2,
    OP_REACH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SEP       = 3'd0,
    REG_REACH     = 3'd1,
    REG_MAX_NODIR = 3'd2,
    REG_RAISE     = 3'd3,
    REG_PATH_PLAN = 3'd4,
    REG_RAND_WALK = 3'd5,
    REG_RST_REACH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic latch;      // capture the input item
    logic tick_sq;    // choose target, square distance to previous target
    logic tick_upd;   // update stuck detector
    logic scan_rd;    // read list entry at scan index
    logic scan_sq;    // square distances to the fetched entry
    logic scan_cmp;   // compare and decide
    logic push;       // write push point into the list
    logic reach;      // apply goal-reached clear
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic point_valid;
    logic scan_more;
    logic tick_push;
    logic scan_stop;
    logic scan_push;
    logic pend2;
  } stat_t;

endpackage

>>> hdl/uta_ctrl.sv
// Controller state machine for the unreachable-target avoidance block.
// Sequences the datapath through commands; depends on uta_pkg.
module uta_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  uta_pkg::stat_t stat,
  output uta_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import uta_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_TSQ   = 10'b0000000100,
    S_TCMP  = 10'b0000001000,
    S_SRD   = 10'b0000010000,
    S_SSQ   = 10'b0000100000,
    S_SCMP  = 10'b0001000000,
    S_PUSH  = 10'b0010000000,
    S_REACH = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_DISP;
      S_DISP: begin
        unique case (stat.op)
          OP_TICK:  state_next = S_TSQ;
          OP_REACH: state_next = S_REACH;
          default:  state_next = stat.point_valid ? S_SRD : S_DONE;
        endcase
      end
      S_TSQ:   state_next = S_TCMP;
      S_TCMP:  state_next = stat.tick_push ? S_PUSH : S_DONE;
      S_SRD:   state_next = stat.scan_more ? S_SSQ : S_DONE;
      S_SSQ:   state_next = S_SCMP;
      S_SCMP: begin
        if (stat.scan_stop) state_next = stat.scan_push ? S_PUSH : S_DONE;
        else                state_next = S_SRD;
      end
      S_PUSH:  state_next = stat.pend2 ? S_PUSH : S_DONE;
      S_REACH: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == S_IDLE) && start;
    cmd.tick_sq  = (state == S_TSQ);
    cmd.tick_upd = (state == S_TCMP);
    cmd.scan_rd  = (state == S_SRD) && stat.scan_more;
    cmd.scan_sq  = (state == S_SSQ);
    cmd.scan_cmp = (state == S_SCMP);
    cmd.push     = (state == S_PUSH);
    cmd.reach    = (state == S_REACH);
  end

endmodule

>>> hdl/uta_dp.sv
// Datapath for the unreachable-target avoidance block: avoid list memory,
// configuration registers, distance squares and stuck detector. Depends on uta_pkg.
module uta_dp #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  uta_pkg::cmd_t      cmd,
  output uta_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         op,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic               point_valid,
  input  logic signed [15:0] sub_x,
  input  logic signed [15:0] sub_y,
  input  logic               sub_valid,
  input  logic               random_walking,
  input  logic signed [8:0]  avoid_angle,
  input  logic [15:0]        remaining_distance,
  output logic               hit,
  output logic [4:0]         list_count,
  output logic               dropped,
  output logic [7:0]         blocked_count,
  output logic [6:0]         angle_limit
);
  import uta_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // configuration
  logic [15:0] sep_thr, reach_dist;
  logic [7:0]  max_nodir;
  logic [6:0]  raise_step;
  logic        path_plan, rand_walk, rst_on_reach;
  logic [31:0] sep2;

  // latched item
  op_t                op_q;
  logic signed [15:0] px, py, sx, sy;
  logic               pv, sv, rw;
  logic signed [8:0]  ang;
  logic [15:0]        remain;

  // list and detector state
  logic [31:0]        mem [LIST_DEPTH];
  logic [31:0]        rd_q;
  logic [CW-1:0]      count, idx;
  logic signed [15:0] prev_x, prev_y;
  logic               prev_v;
  logic [7:0]         blocked;
  logic [6:0]         limit;
  logic               hit_q, dropped_q;

  logic signed [15:0] tx, ty;
  logic               tv;
  logic signed [15:0] push_x, push_y;
  logic               pend2;
  logic [33:0]        sq_a, sq_b, sq_c, sq_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_thr      <= 16'd512;
      reach_dist   <= 16'd256;
      max_nodir    <= 8'd10;
      raise_step   <= 7'd3;
      path_plan    <= 1'b0;
      rand_walk    <= 1'b0;
      rst_on_reach <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEP:       sep_thr      <= cfg_data;
        REG_REACH:     reach_dist   <= cfg_data;
        REG_MAX_NODIR: max_nodir    <= cfg_data[7:0];
        REG_RAISE:     raise_step   <= cfg_data[6:0];
        REG_PATH_PLAN: path_plan    <= cfg_data[0];
        REG_RAND_WALK: rand_walk    <= cfg_data[0];
        REG_RST_REACH: rst_on_reach <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sep2 <= 32'(sep_thr) * 32'(sep_thr);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op_t'(op);
      px     <= point_x;
      py     <= point_y;
      pv     <= point_valid;
      sx     <= sub_x;
      sy     <= sub_y;
      sv     <= sub_valid;
      rw     <= random_walking;
      ang    <= avoid_angle;
      remain <= remaining_distance;
    end
  end

  // target choice
  logic               use_sub;
  logic signed [15:0] sel_x, sel_y;
  logic               sel_v;
  always_comb begin
    use_sub = path_plan ? sv : !pv;
    if (rand_walk && rw) use_sub = 1'b1;
    sel_x = use_sub ? sx : px;
    sel_y = use_sub ? sy : py;
    sel_v = use_sub ? sv : pv;
  end

  // squares: tick uses target vs previous; scan uses entry vs frontier and subtarget
  logic signed [16:0] d_a, d_b, d_c, d_d;
  logic signed [15:0] ex, ey;
  always_comb begin
    ex = rd_q[31:16];
    ey = rd_q[15:0];
    if (cmd.tick_sq) begin
      d_a = 17'(sel_x) - 17'(prev_x);
      d_b = 17'(sel_y) - 17'(prev_y);
    end else begin
      d_a = 17'(ex) - 17'(px);
      d_b = 17'(ey) - 17'(py);
    end
    d_c = 17'(ex) - 17'(sx);
    d_d = 17'(ey) - 17'(sy);
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_sq || cmd.scan_sq) begin
      sq_a <= 34'(d_a * d_a);
      sq_b <= 34'(d_b * d_b);
      sq_c <= 34'(d_c * d_c);
      sq_d <= 34'(d_d * d_d);
    end
    if (cmd.tick_sq) begin
      tx <= sel_x;
      ty <= sel_y;
      tv <= sel_v;
    end
  end

  logic [34:0] sum_p, sum_s;
  logic        near_route, near_p, near_s;
  always_comb begin
    sum_p      = 35'(sq_a) + 35'(sq_b);
    sum_s      = 35'(sq_c) + 35'(sq_d);
    near_route = tv && prev_v && ({sum_p, 2'b00} < 37'(sep2));
    near_p     = sum_p < 35'(sep2);
    near_s     = sv && (sum_s < 35'(sep2));
  end

  // stuck detector
  logic [8:0] mag;
  logic       over;
  logic [7:0] blk_inc, lim_sum;
  logic       tick_push;
  always_comb begin
    mag       = ang[8] ? 9'(-ang) : 9'(ang);
    over      = mag > 9'(limit);
    blk_inc   = (blocked == 8'hFF) ? blocked : blocked + 8'd1;
    lim_sum   = 8'(limit) + 8'(raise_step);
    tick_push = near_route && over && (blk_inc >= max_nodir);
  end

  logic full;
  assign full = (count >= CW'(LIST_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_v    <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      blocked   <= '0;
      limit     <= ANGLE_MAX;
      hit_q     <= 1'b0;
      dropped_q <= 1'b0;
      idx       <= '0;
      pend2     <= 1'b0;
    end else begin
      if (cmd.latch) begin
        hit_q     <= 1'b0;
        dropped_q <= 1'b0;
        idx       <= '0;
        pend2     <= 1'b0;
      end
      if (cmd.tick_upd) begin
        if (near_route) begin
          if (over) begin
            limit   <= (lim_sum > 8'(ANGLE_MAX)) ? ANGLE_MAX : lim_sum[6:0];
            blocked <= tick_push ? 8'd0 : blk_inc;
          end else if (limit != 7'd0) begin
            limit <= limit - 7'd1;
          end
        end else begin
          blocked <= '0;
          limit   <= ANGLE_MAX;
        end
        prev_x <= tx;
        prev_y <= ty;
        prev_v <= tv;
        push_x <= tx;
        push_y <= ty;
        pend2  <= sv && (tx == sx) && (ty == sy) && pv;
      end
      if (cmd.scan_cmp) begin
        if (stat.scan_stop) begin
          hit_q <= 1'b1;
          // frontier near an entry pushes the subtarget, else push the frontier
          push_x <= near_p ? sx : px;
          push_y <= near_p ? sy : py;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      if (cmd.push) begin
        if (full) dropped_q <= 1'b1;
        else      count     <= count + CW'(1);
        if (pend2) begin
          push_x <= px;
          push_y <= py;
          pend2  <= 1'b0;
        end
      end
      if (cmd.reach && rst_on_reach && (remain <= reach_dist)) count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) mem[count[AW-1:0]] <= {push_x, push_y};
    if (cmd.scan_rd) rd_q <= mem[idx[AW-1:0]];
  end

  always_comb begin
    stat.op          = op_q;
    stat.point_valid = pv;
    stat.scan_more   = (idx < count);
    stat.tick_push   = tick_push;
    stat.scan_stop   = near_p || ((op_q == OP_CHECK) && near_s);
    stat.scan_push   = (op_q == OP_CHECK) && (near_p ? sv : 1'b1);
    stat.pend2       = pend2;
  end

  assign hit           = hit_q;
  assign list_count    = 5'(count);
  assign dropped       = dropped_q;
  assign blocked_count = blocked;
  assign angle_limit   = limit;

endmodule

>>> hdl/unreachable_target_avoidance.sv
// Unreachable-target avoidance: avoid list with proximity scan and stuck detector.
// Tick squares the target distance, updates the detector, may push one or two points;
// query/check read, square and compare entries until one hits (no scan with no point),
// check may push; reach may empty the list. One transaction at a time, next start taken
// after done: the entry scan shares one read port and one set of squaring multipliers.
// Result shown for one cycle on done, no stall; sync reset presets count, detector, regs.
module unreachable_target_avoidance #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         op,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic               point_valid,
  input  logic signed [15:0] sub_x,
  input  logic signed [15:0] sub_y,
  input  logic               sub_valid,
  input  logic               random_walking,
  input  logic signed [8:0]  avoid_angle,
  input  logic [15:0]        remaining_distance,
  output logic               hit,
  output logic [4:0]         list_count,
  output logic               dropped,
  output logic [7:0]         blocked_count,
  output logic [6:0]         angle_limit
);
  import uta_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  uta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  uta_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .op                 (op),
    .point_x            (point_x),
    .point_y            (point_y),
    .point_valid        (point_valid),
    .sub_x              (sub_x),
    .sub_y              (sub_y),
    .sub_valid          (sub_valid),
    .random_walking     (random_walking),
    .avoid_angle        (avoid_angle),
    .remaining_distance (remaining_distance),
    .hit                (hit),
    .list_count         (list_count),
    .dropped            (dropped),
    .blocked_count      (blocked_count),
    .angle_limit        (angle_limit)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not start");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe outside a transaction");
  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    angle_limit <= ANGLE_MAX) else $error("angle limit above maximum");
  a_count_flags: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> (32'(list_count) == (LIST_DEPTH % 32)))
    else $error("push dropped while list not full");
`endif

endmodule

>>> dv/uta_checker.sv
// Checker for the unreachable-target avoidance block: predicts each result from
// the accepted commands and register writes, compares on done. Depends on uta_pkg.
`timescale 1ns / 1ps
module uta_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         op,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic               point_valid,
  input  logic signed [15:0] sub_x,
  input  logic signed [15:0] sub_y,
  input  logic               sub_valid,
  input  logic               random_walking,
  input  logic signed [8:0]  avoid_angle,
  input  logic [15:0]        remaining_distance,
  input  logic               hit,
  input  logic [4:0]         list_count,
  input  logic               dropped,
  input  logic [7:0]         blocked_count,
  input  logic [6:0]         angle_limit,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);
  import uta_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic       hit;
    logic [4:0] count;
    logic       dropped;
    logic [7:0] blocked;
    logic [6:0] limit;
  } status_t;

  status_t expected_status[$];

  logic signed [15:0] avoid_x[DEPTH];
  logic signed [15:0] avoid_y[DEPTH];
  int                 n_avoid;
  logic signed [15:0] last_tx, last_ty;
  logic               last_tv;
  int                 stuck_ticks;
  int                 angle_lim;
  longint             sep_q, reach_q, max_nodir, raise_q;
  logic               plan_q, walk_q, clear_q;
  logic               lost;

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  function automatic bit bool_near(longint ax, longint ay, longint bx, longint by);
    return sq_dist(ax, ay, bx, by) < sep_q * sep_q;
  endfunction

  task automatic append_point(logic signed [15:0] x, logic signed [15:0] y);
    if (n_avoid < DEPTH) begin
      avoid_x[n_avoid] = x;
      avoid_y[n_avoid] = y;
      n_avoid++;
    end else begin
      lost = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_status();
    logic signed [15:0] tx, ty;
    logic               tv, use_sub, found;
    int                 mag;
    status_t            s;
    lost = 1'b0;
    s.hit = 1'b0;
    case (op_t'(op))
      OP_TICK: begin
        use_sub = plan_q ? sub_valid : !point_valid;
        if (walk_q && random_walking) use_sub = 1'b1;
        tx = use_sub ? sub_x : point_x;
        ty = use_sub ? sub_y : point_y;
        tv = use_sub ? sub_valid : point_valid;
        if (tv && last_tv && 4 * sq_dist(tx, ty, last_tx, last_ty) < sep_q * sep_q) begin
          mag = (avoid_angle < 0) ? -avoid_angle : avoid_angle;
          if (mag > angle_lim) begin
            if (stuck_ticks < 255) stuck_ticks++;
            angle_lim = angle_lim + int'(raise_q);
            if (angle_lim > int'(ANGLE_MAX)) angle_lim = int'(ANGLE_MAX);
            if (stuck_ticks >= max_nodir) begin
              append_point(tx, ty);
              if (sub_valid && tx == sub_x && ty == sub_y && point_valid)
                append_point(point_x, point_y);
              stuck_ticks = 0;
            end
          end else if (angle_lim > 0) begin
            angle_lim--;
          end
        end else begin
          stuck_ticks = 0;
          angle_lim = int'(ANGLE_MAX);
        end
        last_tx = tx;
        last_ty = ty;
        last_tv = tv;
      end
      OP_QUERY: begin
        if (point_valid)
          for (int i = 0; i < n_avoid; i++)
            if (bool_near(avoid_x[i], avoid_y[i], point_x, point_y)) s.hit = 1'b1;
      end
      OP_CHECK: begin
        found = 1'b0;
        if (point_valid)
          for (int i = 0; i < n_avoid && !found; i++) begin
            if (bool_near(avoid_x[i], avoid_y[i], point_x, point_y)) begin
              if (sub_valid) append_point(sub_x, sub_y);
              found = 1'b1;
            end else if (sub_valid && bool_near(avoid_x[i], avoid_y[i], sub_x, sub_y)) begin
              append_point(point_x, point_y);
              found = 1'b1;
            end
          end
        s.hit = found;
      end
      default: begin
        if (clear_q && longint'(remaining_distance) <= reach_q) n_avoid = 0;
      end
    endcase
    s.count = n_avoid[4:0];
    s.dropped = lost;
    s.blocked = stuck_ticks[7:0];
    s.limit = angle_lim[6:0];
    expected_status = {expected_status, s};
  endtask

  always @(posedge clk) begin
    status_t w;
    if (rst) begin
      n_avoid = 0;
      last_tx = '0;
      last_ty = '0;
      last_tv = 1'b0;
      stuck_ticks = 0;
      angle_lim = int'(ANGLE_MAX);
      sep_q = 512;
      reach_q = 256;
      max_nodir = 10;
      raise_q = 3;
      plan_q = 1'b0;
      walk_q = 1'b0;
      clear_q = 1'b1;
      fail_count = 0;
      result_count <= 0;
      expected_status.delete();
    end else begin
      if (done) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected result, queued", 0, 1);
        end else begin
          w = expected_status.pop_front();
          if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
          if (list_count !== w.count) report_mismatch("list_count", list_count, w.count);
          if (dropped !== w.dropped) report_mismatch("dropped", dropped, w.dropped);
          if (blocked_count !== w.blocked)
            report_mismatch("blocked_count", blocked_count, w.blocked);
          if (angle_limit !== w.limit) report_mismatch("angle_limit", angle_limit, w.limit);
        end
        result_count <= result_count + 1;
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SEP:       sep_q = longint'(cfg_data);
          REG_REACH:     reach_q = longint'(cfg_data);
          REG_MAX_NODIR: max_nodir = longint'(cfg_data[7:0]);
          REG_RAISE:     raise_q = longint'(cfg_data[6:0]);
          REG_PATH_PLAN: plan_q = cfg_data[0];
          REG_RAND_WALK: walk_q = cfg_data[0];
          REG_RST_REACH: clear_q = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) predict_status();
    end
    pending <= expected_status.size();
  end
endmodule

>>> dv/tb_unreachable_target_avoidance.sv
// Top of the unreachable-target avoidance testbench: clock, reset, stimulus, verdict.
// Depends on uta_pkg, the block and uta_checker.
`timescale 1ns / 1ps
module tb_unreachable_target_avoidance;
  import uta_pkg::*;

  logic               clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic [1:0]         op;
  logic signed [15:0] point_x, point_y, sub_x, sub_y;
  logic               point_valid, sub_valid, random_walking;
  logic signed [8:0]  avoid_angle;
  logic [15:0]        remaining_distance;
  logic               hit, dropped;
  logic [4:0]         list_count;
  logic [7:0]         blocked_count;
  logic [6:0]         angle_limit;
  int                 fail_count, pending, result_count;
  int                 cycle_count = 0;
  int                 hub_x, hub_y;

  localparam int CYCLE_LIMIT = 400000;

  unreachable_target_avoidance uut (.*);
  uta_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("unreachable_target_avoidance test failed");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop start on the falling edge that follows the accepting edge, then wait for another
  // falling edge so the next transaction never raises it in the same step; the block is still busy.
  task automatic send_command(logic [1:0] o, int px, int py, logic pv, int sx, int sy,
                              logic sv, logic rw, int ang, int rem);
    op <= o;
    point_x <= px[15:0];
    point_y <= py[15:0];
    point_valid <= pv;
    sub_x <= sx[15:0];
    sub_y <= sy[15:0];
    sub_valid <= sv;
    random_walking <= rw;
    avoid_angle <= ang[8:0];
    remaining_distance <= rem[15:0];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0 || start) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Mostly points clustered near a moving hub, so ticks stay on route and hit.
  function automatic int coord(int hub);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 65535) - 32768;
    if (r == 1) return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
    r = hub + $urandom_range(0, 300) - 150;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic random_phase(int items);
    logic [1:0] o;
    int         r;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      o = (r < 55) ? OP_TICK : (r < 75) ? OP_QUERY : (r < 92) ? OP_CHECK : OP_REACH;
      if ($urandom_range(0, 40) == 0) begin
        hub_x = $urandom_range(0, 65535) - 32768;
        hub_y = $urandom_range(0, 65535) - 32768;
      end
      // angles occasionally span the whole 9-bit field
      send_command(o, coord(hub_x), coord(hub_y), $urandom_range(0, 7) != 0,
                   coord(hub_x), coord(hub_y), $urandom_range(0, 2) != 0,
                   1'($urandom_range(0, 1)),
                   ($urandom_range(0, 30) == 0) ? $urandom_range(0, 511) - 256
                                                : $urandom_range(0, 360) - 180,
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 600));
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    op = OP_TICK;
    point_x = '0;
    point_y = '0;
    point_valid = 1'b0;
    sub_x = '0;
    sub_y = '0;
    sub_valid = 1'b0;
    random_walking = 1'b0;
    avoid_angle = '0;
    remaining_distance = '0;
    hub_x = 0;
    hub_y = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: fast pushes, same-point ticks, both frontier pushes, full list.
    write_reg(REG_MAX_NODIR, 1);
    write_reg(REG_RAISE, 0);
    send_command(OP_QUERY, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    send_command(OP_CHECK, 0, 0, 1, 0, 0, 1, 0, 0, 0);
    send_command(OP_TICK, 100, 100, 1, 0, 0, 0, 0, 180, 0);
    send_command(OP_TICK, 100, 100, 1, 0, 0, 0, 0, -180, 0);
    send_command(OP_TICK, 100, 100, 1, 0, 0, 0, 0, 0, 0);
    send_command(OP_TICK, 0, 0, 0, 100, 100, 1, 0, 180, 0);
    send_command(OP_TICK, 32767, -32768, 1, 100, 100, 1, 1, -180, 0);
    send_command(OP_QUERY, 110, 90, 1, 0, 0, 0, 0, 0, 0);
    send_command(OP_QUERY, 110, 90, 0, 0, 0, 0, 0, 0, 0);
    send_command(OP_CHECK, 100, 100, 1, -32768, 32767, 1, 0, 0, 0);
    send_command(OP_CHECK, -5000, 5000, 1, 100, 100, 1, 0, 0, 0);
    send_command(OP_CHECK, 100, 100, 0, 0, 0, 1, 0, 0, 0);
    drain();
    write_reg(REG_PATH_PLAN, 1);
    write_reg(REG_RAND_WALK, 1);
    for (int k = 0; k < 12; k++)
      send_command(OP_TICK, 3000, 3000, 1, 200, 200, 1, 1, 181 - k, 0);
    send_command(OP_REACH, 0, 0, 0, 0, 0, 0, 0, 0, 257);
    send_command(OP_REACH, 0, 0, 0, 0, 0, 0, 0, 0, 256);
    drain();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SEP, ph == 0 ? 0 : ph == 1 ? 65535 : $urandom_range(64, 2000));
      write_reg(REG_REACH, ph == 2 ? 0 : ph == 3 ? 65535 : $urandom_range(0, 600));
      write_reg(REG_MAX_NODIR, ph == 4 ? 255 : ph == 5 ? 1 : $urandom_range(1, 6));
      write_reg(REG_RAISE, ph == 1 ? 89 : ph == 0 ? 0 : $urandom_range(0, 10));
      write_reg(REG_PATH_PLAN, $urandom_range(0, 1));
      write_reg(REG_RAND_WALK, $urandom_range(0, 1));
      write_reg(REG_RST_REACH, ph == 2 ? 0 : $urandom_range(0, 1));
      random_phase(105);
      drain();
    end

    $display("checked %0d results: directed cases, then six random register settings",
             result_count);
    $display("with all ops, wide angles, full and cleared lists");
    if (fail_count == 0 && pending == 0)
      $display("unreachable_target_avoidance test passed");
    else
      $display("unreachable_target_avoidance test failed");
    $finish;
  end
endmodule
